>>> hdl/pts_pkg.sv
// ============================================================================
// pts_pkg: shared types and constants for the periodic timer scheduler
// Request and result codes, and the command/status bundles that pass
// between the controller and the datapath.
// ============================================================================
`default_nettype none

package pts_pkg;

  // request kinds carried in the input tuser
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_ADD  = 2'd1;
  localparam logic [1:0] REQ_DEL  = 2'd2;

  // result codes carried in the output tuser
  localparam logic [2:0] RES_NONE   = 3'd0;
  localparam logic [2:0] RES_FIRED  = 3'd1;
  localparam logic [2:0] RES_FREED  = 3'd2;
  localparam logic [2:0] RES_ADDED  = 3'd3;
  localparam logic [2:0] RES_FULL   = 3'd4;
  localparam logic [2:0] RES_MARKED = 3'd5;

  localparam logic [31:0] COUNT_FOREVER = 32'hFFFF_FFFF;

  localparam int SEL_W    = 4;
  localparam int PERIOD_W = 32;
  localparam int COUNT_W  = 32;
  localparam int TIME_W   = 64;
  localparam int CODE_W   = 3;
  localparam int REQ_W    = 2;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the request, restart the scan
    logic scan;   // read one slot and advance the scan index
    logic exec;   // commit the request and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // scan index sits on the last slot
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/pts_ctrl.sv
// ============================================================================
// pts_ctrl: request sequencer
// Accepts one request, runs the slot scan for tick and add, then commits.
// ============================================================================
`default_nettype none

module pts_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic [pts_pkg::REQ_W-1:0]       in_req,
  output logic                                 in_ready,
  input  wire pts_pkg::sts_t                   sts,
  output pts_pkg::cmd_t                        cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_req == pts_pkg::REQ_TICK || in_req == pts_pkg::REQ_ADD) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pts_datapath.sv
// ============================================================================
// pts_datapath: timer table, scan unit and result register
// Holds the slot table, finds the earliest valid slot and the lowest free
// slot in one pass, and applies the request.
// ============================================================================
`default_nettype none

module pts_datapath #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pts_pkg::cmd_t                      cmd,
  output pts_pkg::sts_t                           sts,
  input  wire logic [pts_pkg::REQ_W-1:0]          in_req,
  input  wire logic [pts_pkg::SEL_W-1:0]          in_sel,
  input  wire logic [pts_pkg::PERIOD_W-1:0]       in_period,
  input  wire logic [pts_pkg::COUNT_W-1:0]        in_count,
  input  wire logic [pts_pkg::TIME_W-1:0]         in_now,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [pts_pkg::CODE_W-1:0]              out_code,
  output logic [pts_pkg::SEL_W-1:0]               out_slot
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

  typedef struct packed {
    logic [pts_pkg::TIME_W-1:0]   due;
    logic [pts_pkg::COUNT_W-1:0]  remaining;
    logic [pts_pkg::PERIOD_W-1:0] period;
  } entry_t;

  // captured request
  logic [pts_pkg::REQ_W-1:0]    req;
  logic [pts_pkg::SEL_W-1:0]    sel;
  logic [pts_pkg::PERIOD_W-1:0] period;
  logic [pts_pkg::COUNT_W-1:0]  count;
  logic [pts_pkg::TIME_W-1:0]   now;

  // table
  entry_t                  mem [TIMER_SLOTS];
  entry_t                  rd_data;
  logic [TIMER_SLOTS-1:0]  valid;
  logic [TIMER_SLOTS-1:0]  marked;

  // scan
  logic [SLOT_W-1:0]           idx;
  logic                        cmp_vld;
  logic [SLOT_W-1:0]           cmp_idx;
  logic                        found;
  logic [SLOT_W-1:0]           best_idx;
  logic [pts_pkg::TIME_W-1:0]  best_due;
  logic [pts_pkg::PERIOD_W-1:0] best_period;
  logic [pts_pkg::COUNT_W-1:0] best_rem;
  logic                        free_found;
  logic [SLOT_W-1:0]           free_idx;
  logic                        take;

  // commit
  logic [pts_pkg::PERIOD_W-1:0] add_period;
  logic [pts_pkg::TIME_W-1:0]   new_due;
  logic [pts_pkg::COUNT_W-1:0]  rem_dec;
  logic                         sel_ok;
  logic [SLOT_W-1:0]            sel_idx;

  assign sts.scan_last = (idx == LAST_SLOT);
  assign sts.out_free  = !out_valid || out_ready;

  assign take = cmp_vld && valid[cmp_idx] && (!found || rd_data.due < best_due);

  assign add_period = (req == pts_pkg::REQ_ADD) ? period : best_period;
  assign new_due    = now + {{(pts_pkg::TIME_W-pts_pkg::PERIOD_W){1'b0}}, add_period};
  assign rem_dec    = (best_rem == pts_pkg::COUNT_FOREVER) ? best_rem : best_rem - 1'b1;
  assign sel_ok     = ({5'd0, sel} < 9'(TIMER_SLOTS));
  assign sel_idx    = SLOT_W'(sel);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req    <= in_req;
      sel    <= in_sel;
      period <= in_period;
      count  <= in_count;
      now    <= in_now;
    end
  end

  // scan index and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      idx        <= '0;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan;
      if (cmd.scan) begin
        idx <= idx + 1'b1;
      end
      if (take) begin
        found <= 1'b1;
      end
      if (cmp_vld && !valid[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= idx;
      rd_data <= mem[idx];
    end
    if (take) begin
      best_idx    <= cmp_idx;
      best_due    <= rd_data.due;
      best_period <= rd_data.period;
      best_rem    <= rd_data.remaining;
    end
    if (cmp_vld && !valid[cmp_idx] && !free_found) begin
      free_idx <= cmp_idx;
    end
  end

  // table write port
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (req == pts_pkg::REQ_ADD && free_found) begin
        mem[free_idx] <= '{due: new_due, remaining: count, period: period};
      end else if (req == pts_pkg::REQ_TICK && found && !marked[best_idx] &&
                   best_rem != '0 && best_due <= now) begin
        mem[best_idx] <= '{due: new_due, remaining: rem_dec, period: best_period};
      end
    end
  end

  // marked bits: no reset, an add always clears the bit of its slot
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (req == pts_pkg::REQ_ADD && free_found) begin
        marked[free_idx] <= 1'b0;
      end else if (req == pts_pkg::REQ_DEL && sel_ok) begin
        marked[sel_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.exec) begin
      if (req == pts_pkg::REQ_ADD && free_found) begin
        valid[free_idx] <= 1'b1;
      end else if (req == pts_pkg::REQ_TICK && found &&
                   (marked[best_idx] || best_rem == '0)) begin
        valid[best_idx] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_code <= pts_pkg::RES_NONE;
      out_slot <= '0;
      case (req)
        pts_pkg::REQ_TICK: begin
          if (found) begin
            if (marked[best_idx] || best_rem == '0) begin
              out_code <= pts_pkg::RES_FREED;
              out_slot <= pts_pkg::SEL_W'(best_idx);
            end else if (best_due <= now) begin
              out_code <= pts_pkg::RES_FIRED;
              out_slot <= pts_pkg::SEL_W'(best_idx);
            end
          end
        end
        pts_pkg::REQ_ADD: begin
          if (free_found) begin
            out_code <= pts_pkg::RES_ADDED;
            out_slot <= pts_pkg::SEL_W'(free_idx);
          end else begin
            out_code <= pts_pkg::RES_FULL;
          end
        end
        pts_pkg::REQ_DEL: begin
          if (sel_ok) begin
            out_code <= pts_pkg::RES_MARKED;
            out_slot <= sel;
          end
        end
        default: begin
          out_code <= pts_pkg::RES_NONE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/periodic_timer_scheduler.sv
// ============================================================================
// periodic_timer_scheduler: table of periodic software-style timers
// Add, delete and tick requests against a table of TIMER_SLOTS timers; each
// request returns exactly one result.
// ============================================================================
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid / s_axis_tready tuser: request kind
//                                                     tdata: slot, period,
//                                                     repeat count, time
//  m_axis    out        m_axis_tvalid / m_axis_tready tuser: result code
//                                                     tdata: slot
//
// Steps: a tick or add request goes through accept, one table read per slot
// in a single-port scan over the slot table, one compare drain, and commit.
// Delete and unused requests go from accept straight to commit.
// Reset: rst is synchronous; it empties the table and the result register.
// Stalls: a held result (m_axis_tready low) holds the commit step; the request
// being served is accepted and scanned meanwhile, and no new one is accepted until it commits.
// ============================================================================
`default_nettype none

module periodic_timer_scheduler #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // [3:0] slot_sel, [35:4] period_ms, [67:36] repeat_count,
  // [131:68] now_ms, [135:132] zero
  input  wire logic [135:0]  s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // [3:0] slot_out, [7:4] zero
  output logic [7:0]         m_axis_tdata,
  // [2:0] result_code
  output logic [2:0]         m_axis_tuser
);

  pts_pkg::cmd_t cmd;
  pts_pkg::sts_t sts;
  logic [pts_pkg::SEL_W-1:0] slot_out;

  // sequencer: accept, scan, drain, commit
  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_req   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, scan and result register; unpack the request fields here
  pts_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (s_axis_tuser),
    .in_sel    (s_axis_tdata[3:0]),
    .in_period (s_axis_tdata[35:4]),
    .in_count  (s_axis_tdata[67:36]),
    .in_now    (s_axis_tdata[131:68]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_code  (m_axis_tuser),
    .out_slot  (slot_out)
  );

  // pad the slot up to a whole byte
  assign m_axis_tdata = {4'd0, slot_out};

  // commit only when the result register can take the result
  a_exec_room: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> sts.out_free)
    else $error("commit while result register is occupied");

  // every commit presents a result on the next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> m_axis_tvalid)
    else $error("commit did not produce a result");

  // no new request is taken while the table is being scanned
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !s_axis_tready)
    else $error("input ready during scan");

  // loading a request never overlaps scan or commit
  a_load_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!cmd.scan && !cmd.exec))
    else $error("load overlaps scan or commit");

endmodule

`default_nettype wire
